[hdl/srtf_tick_scheduler_defines.svh]
// Assertion macros shared by the scheduler RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef SRTF_TICK_SCHEDULER_DEFINES_SVH
`define SRTF_TICK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRTF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRTF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/srtf_pkg.sv]
// Shared constants, types and the sequencer microcode for the SRTF scheduler.
// No dependencies; every other file but the assertion macro header imports this package.
`default_nettype none

package srtf_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int TIME_BITS_DEF   = 16;

    localparam int OP_W     = 2;
    localparam int INDEX_W  = 4;
    localparam int FIELD_W  = 16;
    localparam int PCOUNT_W = 5;
    localparam int STEP_W   = 4;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_TICK  = 2'd1,
        OP_STATS = 2'd2,
        OP_NONE  = 2'd3
    } srtf_op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_TICK,
        C_LOAD,
        C_EMPTY,
        C_MORE
    } srtf_cond_t;

    localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DECODE = 4'd1;
    localparam logic [STEP_W-1:0] STEP_BRANCH = 4'd2;
    localparam logic [STEP_W-1:0] STEP_INFO   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_LOAD   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_TSTART = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SCAN   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DRAIN  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_FIN    = 4'd8;

    typedef struct packed {
        logic              wait_in;
        logic              wait_out;
        logic              rd_idx;
        logic              scan_init;
        logic              scan_rd;
        logic              wr_load;
        logic              res_info;
        logic              tick_fin;
        srtf_cond_t        cond;
        logic [STEP_W-1:0] target;
    } srtf_uword_t;

    typedef struct packed {
        logic in_valid;
        logic ok_out;
        logic is_tick;
        logic is_load;
        logic is_empty;
        logic more;
    } srtf_stat_t;

    typedef struct packed {
        logic in_ready;
        logic rd_idx;
        logic scan_init;
        logic scan_rd;
        logic wr_load;
        logic res_info;
        logic tick_fin;
    } srtf_ctrl_t;

    function automatic srtf_uword_t srtf_ucode(input logic [STEP_W-1:0] step);
        srtf_uword_t w;
        w = '0;
        w.cond = C_NEXT;
        case (step)
            STEP_WAIT:
            begin
                w.wait_in = 1'b1;
            end
            STEP_DECODE:
            begin
                w.rd_idx = 1'b1;
                w.cond   = C_TICK;
                w.target = STEP_TSTART;
            end
            STEP_BRANCH:
            begin
                w.cond   = C_LOAD;
                w.target = STEP_LOAD;
            end
            STEP_INFO:
            begin
                w.wait_out = 1'b1;
                w.res_info = 1'b1;
                w.cond     = C_ALWAYS;
                w.target   = STEP_WAIT;
            end
            STEP_LOAD:
            begin
                w.wait_out = 1'b1;
                w.wr_load  = 1'b1;
                w.res_info = 1'b1;
                w.cond     = C_ALWAYS;
                w.target   = STEP_WAIT;
            end
            STEP_TSTART:
            begin
                w.scan_init = 1'b1;
                w.cond      = C_EMPTY;
                w.target    = STEP_FIN;
            end
            STEP_SCAN:
            begin
                w.scan_rd = 1'b1;
                w.cond    = C_MORE;
                w.target  = STEP_SCAN;
            end
            STEP_DRAIN:
            begin
                w.cond = C_NEXT;
            end
            STEP_FIN:
            begin
                w.wait_out = 1'b1;
                w.tick_fin = 1'b1;
                w.cond     = C_ALWAYS;
                w.target   = STEP_WAIT;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hdl/srtf_if.sv]
// Request and response channel interfaces with valid/ready handshake.
// Depends on srtf_pkg for the field widths.
`default_nettype none

interface srtf_req_if;
    import srtf_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [INDEX_W-1:0] entry_index;
    logic [FIELD_W-1:0] arrival_time;
    logic [FIELD_W-1:0] burst_length;

    modport source (output valid, operation, entry_index, arrival_time, burst_length,
                    input ready);
    modport sink (input valid, operation, entry_index, arrival_time, burst_length,
                  output ready);
endinterface

interface srtf_rsp_if;
    import srtf_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] tick_time;
    logic               is_idle;
    logic [INDEX_W-1:0] chosen_index;
    logic [FIELD_W-1:0] turnaround_count;
    logic [FIELD_W-1:0] waiting_count;
    logic [FIELD_W-1:0] remaining_left;

    modport source (output valid, tick_time, is_idle, chosen_index, turnaround_count,
                    waiting_count, remaining_left, input ready);
    modport sink (input valid, tick_time, is_idle, chosen_index, turnaround_count,
                  waiting_count, remaining_left, output ready);
endinterface

`default_nettype wire

[hdl/srtf_tick_scheduler.sv]
// A load, stats or unknown request passes through the decode and branch steps to the load or
// info step, which registers its result once the output register is free. A tick scans
// N = min(process_count, MAX_ENTRIES) entries of the process table, which has one read and one
// write port, one entry per cycle, then drains and finishes; with N of 0 it skips the scan.
// One request at a time; the next is taken the cycle after a result is registered, even while
// it waits. Reset clears time, process_count and control; the table is undefined until loaded.
`default_nettype none
`include "srtf_tick_scheduler_defines.svh"

module srtf_tick_scheduler #(
    parameter int MAX_ENTRIES = srtf_pkg::MAX_ENTRIES_DEF,
    parameter int TIME_BITS   = srtf_pkg::TIME_BITS_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_write_en,
    input  wire [srtf_pkg::PCOUNT_W-1:0]   cfg_write_data,
    srtf_req_if.sink                       req,
    srtf_rsp_if.source                     rsp
);
    import srtf_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    srtf_stat_t stat;
    srtf_ctrl_t ctrl;

    srtf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // Configuration and time.
    logic [PCOUNT_W-1:0]  process_count_reg;
    logic [TIME_BITS-1:0] time_now_reg;
    logic [TIME_BITS-1:0] time_now_next;
    logic [CNT_W-1:0]     scan_count;

    // Latched request.
    logic [OP_W-1:0]      req_op_reg;
    logic [INDEX_W-1:0]   req_idx_reg;
    logic [TIME_BITS-1:0] req_arr_reg;
    logic [TIME_BITS-1:0] req_burst_reg;
    logic                 req_accept;
    logic                 idx_ok;
    logic [IDX_W-1:0]     req_addr;

    // Process table.
    logic [TIME_BITS-1:0] arr_mem [MAX_ENTRIES];
    logic [TIME_BITS-1:0] rem_mem [MAX_ENTRIES];
    logic [TIME_BITS-1:0] trn_mem [MAX_ENTRIES];
    logic [TIME_BITS-1:0] wt_mem  [MAX_ENTRIES];
    logic [TIME_BITS-1:0] rd_arr_reg;
    logic [TIME_BITS-1:0] rd_rem_reg;
    logic [TIME_BITS-1:0] rd_trn_reg;
    logic [TIME_BITS-1:0] rd_wt_reg;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [TIME_BITS-1:0] wr_arr;
    logic [TIME_BITS-1:0] wr_rem;
    logic [TIME_BITS-1:0] wr_trn;
    logic [TIME_BITS-1:0] wr_wt;

    // Scan state.
    logic [CNT_W-1:0]     rd_ptr_reg;
    logic                 pv_reg;
    logic [IDX_W-1:0]     pidx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [TIME_BITS-1:0] best_arr_reg;
    logic [TIME_BITS-1:0] best_rem_reg;
    logic [TIME_BITS-1:0] best_trn_reg;
    logic [TIME_BITS-1:0] best_wt_reg;
    logic                 active;
    logic                 better;
    logic [TIME_BITS-1:0] trn_inc;
    logic [TIME_BITS-1:0] wt_inc;
    logic [TIME_BITS-1:0] best_trn_inc;

    // Output register.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [FIELD_W-1:0]   out_time_reg;
    logic                 out_idle_reg;
    logic [INDEX_W-1:0]   out_chosen_reg;
    logic [FIELD_W-1:0]   out_trn_reg;
    logic [FIELD_W-1:0]   out_wt_reg;
    logic [FIELD_W-1:0]   out_rem_reg;
    logic                 ok_out;

    assign req.ready  = ctrl.in_ready;
    assign req_accept = req.valid && req.ready;
    assign ok_out     = !out_valid_reg || rsp.ready;

    always_comb
    begin
        if (32'(process_count_reg) > 32'(MAX_ENTRIES))
        begin
            scan_count = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            scan_count = CNT_W'(process_count_reg);
        end
    end

    assign idx_ok   = 32'(req_idx_reg) < 32'(MAX_ENTRIES);
    assign req_addr = IDX_W'(req_idx_reg);

    assign stat.in_valid = req.valid;
    assign stat.ok_out   = ok_out;
    assign stat.is_tick  = req_op_reg == OP_TICK;
    assign stat.is_load  = req_op_reg == OP_LOAD;
    assign stat.is_empty = scan_count == '0;
    assign stat.more     = ((CNT_W+1)'(rd_ptr_reg) + 1'b1) < (CNT_W+1)'(scan_count);

    assign time_now_next = (time_now_reg == '1) ? time_now_reg : time_now_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_count_reg <= '0;
            time_now_reg      <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                process_count_reg <= cfg_write_data;
            end
            if (ctrl.tick_fin)
            begin
                time_now_reg <= time_now_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_op_reg    <= req.operation;
            req_idx_reg   <= req.entry_index;
            req_arr_reg   <= TIME_BITS'(req.arrival_time);
            req_burst_reg <= TIME_BITS'(req.burst_length);
        end
    end

    // Entry evaluation for the word read in the previous scan cycle.
    always_comb
    begin
        active = (rd_arr_reg <= time_now_reg) && (rd_rem_reg != '0);
        better = !found_reg || (rd_rem_reg < best_rem_reg) ||
                 ((rd_rem_reg == best_rem_reg) && (rd_arr_reg < best_arr_reg));
        trn_inc      = (rd_trn_reg == '1) ? rd_trn_reg : rd_trn_reg + 1'b1;
        wt_inc       = (rd_wt_reg == '1) ? rd_wt_reg : rd_wt_reg + 1'b1;
        best_trn_inc = (best_trn_reg == '1) ? best_trn_reg : best_trn_reg + 1'b1;
    end

    assign rd_en   = ctrl.rd_idx || ctrl.scan_rd;
    assign rd_addr = ctrl.scan_rd ? rd_ptr_reg[IDX_W-1:0] : req_addr;

    // Every active entry is written back with both counters bumped during the scan.
    // The winner is then rewritten from its captured original record, so it gets
    // the turnaround count but not the waiting count.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = req_addr;
        wr_arr  = req_arr_reg;
        wr_rem  = req_burst_reg;
        wr_trn  = '0;
        wr_wt   = '0;
        if (ctrl.wr_load)
        begin
            wr_en = idx_ok;
        end
        else if (pv_reg && active)
        begin
            wr_en   = 1'b1;
            wr_addr = pidx_reg;
            wr_arr  = rd_arr_reg;
            wr_rem  = rd_rem_reg;
            wr_trn  = trn_inc;
            wr_wt   = wt_inc;
        end
        else if (ctrl.tick_fin && found_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = best_idx_reg;
            wr_arr  = best_arr_reg;
            wr_rem  = best_rem_reg - 1'b1;
            wr_trn  = best_trn_inc;
            wr_wt   = best_wt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            arr_mem[wr_addr] <= wr_arr;
            rem_mem[wr_addr] <= wr_rem;
            trn_mem[wr_addr] <= wr_trn;
            wt_mem[wr_addr]  <= wr_wt;
        end
        if (rd_en)
        begin
            rd_arr_reg <= arr_mem[rd_addr];
            rd_rem_reg <= rem_mem[rd_addr];
            rd_trn_reg <= trn_mem[rd_addr];
            rd_wt_reg  <= wt_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            pv_reg     <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            pv_reg <= ctrl.scan_rd;
            if (ctrl.scan_init)
            begin
                rd_ptr_reg <= '0;
                found_reg  <= 1'b0;
            end
            else
            begin
                if (ctrl.scan_rd)
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
                if (pv_reg && active && better)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.scan_rd)
        begin
            pidx_reg <= rd_ptr_reg[IDX_W-1:0];
        end
        if (pv_reg && active && better)
        begin
            best_idx_reg <= pidx_reg;
            best_arr_reg <= rd_arr_reg;
            best_rem_reg <= rd_rem_reg;
            best_trn_reg <= rd_trn_reg;
            best_wt_reg  <= rd_wt_reg;
        end
    end

    // Result register.
    always_comb
    begin
        if (ctrl.res_info || ctrl.tick_fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.res_info)
        begin
            out_time_reg   <= FIELD_W'(time_now_reg);
            out_idle_reg   <= 1'b0;
            out_chosen_reg <= '0;
            if ((req_op_reg == OP_STATS) && idx_ok)
            begin
                out_trn_reg <= FIELD_W'(rd_trn_reg);
                out_wt_reg  <= FIELD_W'(rd_wt_reg);
                out_rem_reg <= FIELD_W'(rd_rem_reg);
            end
            else
            begin
                out_trn_reg <= '0;
                out_wt_reg  <= '0;
                out_rem_reg <= '0;
            end
        end
        else if (ctrl.tick_fin)
        begin
            out_time_reg   <= FIELD_W'(time_now_reg);
            out_idle_reg   <= !found_reg;
            out_chosen_reg <= found_reg ? INDEX_W'(best_idx_reg) : '0;
            out_trn_reg    <= '0;
            out_wt_reg     <= '0;
            out_rem_reg    <= '0;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.tick_time        = out_time_reg;
    assign rsp.is_idle          = out_idle_reg;
    assign rsp.chosen_index     = out_chosen_reg;
    assign rsp.turnaround_count = out_trn_reg;
    assign rsp.waiting_count    = out_wt_reg;
    assign rsp.remaining_left   = out_rem_reg;

    `SRTF_ASSERT_NXT(a_time_step, ctrl.tick_fin && (time_now_reg != '1),
        time_now_reg == $past(time_now_reg) + 1'b1, "tick did not advance time by one")
    `SRTF_ASSERT_IMP(a_out_free, ctrl.res_info || ctrl.tick_fin,
        !out_valid_reg || rsp.ready, "result written over an undelivered result")
    `SRTF_ASSERT_IMP(a_port_clash, pv_reg,
        !ctrl.wr_load && !ctrl.tick_fin, "scan write-back collides with another write")
    `SRTF_ASSERT_IMP(a_scan_range, pv_reg,
        (CNT_W+1)'(pidx_reg) < (CNT_W+1)'(scan_count), "scan visited an entry out of range")

endmodule

`default_nettype wire

[hdl/srtf_seq.sv]
// Microcoded sequencer: step counter, microcode table and conditional jumps.
// Depends on srtf_pkg for the control word, status and control types.
`default_nettype none

module srtf_seq (
    input  wire                     clk,
    input  wire                     rst_n,
    input  srtf_pkg::srtf_stat_t    stat,
    output srtf_pkg::srtf_ctrl_t    ctrl
);
    import srtf_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    srtf_uword_t       uw;
    logic              hold;
    logic              take;

    always_comb
    begin
        uw   = srtf_ucode(step_reg);
        // A step that waits on a channel neither acts nor advances.
        hold = (uw.wait_in && !stat.in_valid) || (uw.wait_out && !stat.ok_out);
        case (uw.cond)
            C_NEXT:   take = 1'b0;
            C_ALWAYS: take = 1'b1;
            C_TICK:   take = stat.is_tick;
            C_LOAD:   take = stat.is_load;
            C_EMPTY:  take = stat.is_empty;
            C_MORE:   take = stat.more;
            default:  take = 1'b1;
        endcase
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (take)
        begin
            step_next = uw.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
        ctrl.in_ready  = uw.wait_in;
        ctrl.rd_idx    = uw.rd_idx && !hold;
        ctrl.scan_init = uw.scan_init && !hold;
        ctrl.scan_rd   = uw.scan_rd && !hold;
        ctrl.wr_load   = uw.wr_load && !hold;
        ctrl.res_info  = uw.res_info && !hold;
        ctrl.tick_fin  = uw.tick_fin && !hold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire
